[design/poisson_disk_admission_grid_core_defines.svh]
// Assertion macros shared by the checker of the admission grid core.
`ifndef POISSON_DISK_ADMISSION_GRID_CORE_DEFINES_SVH
`define POISSON_DISK_ADMISSION_GRID_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PDAG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PDAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pdag_pkg.sv]
// Types, constants and codes shared by the admission grid core modules.
package pdag_pkg;

    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ROW_W      = $clog2(GRID_ROWS);

    localparam int COORD_W    = 14;
    localparam int DIM_W      = 13;
    localparam int SP_W       = 11;
    localparam int CS_W       = 11;
    localparam int CNT_W      = 13;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_COL_W  = 6;
    localparam int OUT_ROW_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int QUO_W      = DIM_W;
    localparam int REM_W      = CS_W;
    localparam int GAP_W      = 13;
    localparam int DIFF_W     = 16;
    localparam int SQ_W       = 2 * GAP_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int POS_W      = QUO_W + 2;

    localparam int WIN        = 5;
    localparam int WIN_W      = $clog2(WIN + 1);
    localparam int HALF_WIN   = WIN / 2;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQ_OPS     = 2 * WIN + 1;
    localparam int SQ_IDX_W   = $clog2(SQ_OPS);
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(4096);

    localparam logic [DIM_W-1:0] AREA_WIDTH_RST  = DIM_W'(1024);
    localparam logic [DIM_W-1:0] AREA_HEIGHT_RST = DIM_W'(768);
    localparam logic [SP_W-1:0]  SPACING_RST     = SP_W'(64);
    localparam logic [CS_W-1:0]  CELL_SIZE_RST   = CS_W'(45);

    localparam logic [FUNC_W-1:0] FUNC_SEED      = 2'd1;
    localparam int                FUNC_CLEAR_BIT = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ACCEPTED  = 2'd0,
        STAT_OUTSIDE   = 2'd1,
        STAT_TOO_CLOSE = 2'd2,
        STAT_CLEARED   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_EVAL,
        S_SQ,
        S_SCAN_RD,
        S_SCAN,
        S_INS_RD,
        S_INS_WR
    } fsm_state_t;

    typedef struct packed {
        logic                load;
        logic                div_step;
        logic                sq_en;
        logic [SQ_IDX_W-1:0] sq_idx;
        logic                scan_chk;
        logic [WIN_W-1:0]    ki;
        logic [WIN_W-1:0]    kj;
        logic                rd_en;
        logic [WIN_W-1:0]    rd_kj;
        logic                ins_rd;
        logic                ins_wr;
        logic                clr;
        logic                emit;
        status_t             emit_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic is_seed;
        logic outside;
        logic hit;
    } dp_stat_t;

    typedef struct packed {
        logic                 rd_en;
        logic [ROW_W-1:0]     rd_addr;
        logic                 wr_en;
        logic [ROW_W-1:0]     wr_addr;
        logic [GRID_COLS-1:0] wr_data;
        logic                 clr;
    } grid_req_t;

endpackage

[design/pdag_grid.sv]
// Occupancy grid: one row per memory word, row valid flags for instant clear.
module pdag_grid (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdag_pkg::grid_req_t           req,
    output logic [pdag_pkg::GRID_COLS-1:0] rd_data,
    output logic                          rd_vld
);
    import pdag_pkg::*;

    logic [GRID_COLS-1:0] occ_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] row_vld_reg;
    logic [GRID_COLS-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            occ_mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= occ_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                row_vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                row_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= row_vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_vld  = rd_vld_reg;

endmodule

[design/pdag_div.sv]
// Restoring divider lane, one quotient bit per step.
module pdag_div (
    input  logic                       clk,
    input  logic                       load,
    input  logic                       step,
    input  logic [pdag_pkg::QUO_W-1:0] dividend,
    input  logic [pdag_pkg::CS_W-1:0]  divisor,
    output logic [pdag_pkg::QUO_W-1:0] quot,
    output logic [pdag_pkg::REM_W-1:0] rem
);
    import pdag_pkg::*;

    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [REM_W:0]   shifted;
    logic [REM_W:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[QUO_W-1]};
        diff     = shifted - {1'b0, divisor};
        ge       = (shifted >= {1'b0, divisor});
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (load)
        begin
            quo_next = dividend;
            rem_next = '0;
        end
        else if (step)
        begin
            quo_next = {quo_reg[QUO_W-2:0], ge};
            rem_next = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

[design/pdag_ctrl.sv]
// Controller: sequences divide, squaring, neighborhood scan and insert.
module pdag_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pdag_pkg::dp_stat_t   stat,
    output pdag_pkg::ctrl_cmd_t  cmd
);
    import pdag_pkg::*;

    fsm_state_t        state_reg;
    fsm_state_t        state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic [WIN_W-1:0]  ki_reg;
    logic [WIN_W-1:0]  ki_next;
    logic [WIN_W-1:0]  kj_reg;
    logic [WIN_W-1:0]  kj_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ki_reg    <= '0;
            kj_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ki_reg    <= ki_next;
            kj_reg    <= kj_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ki_next    = ki_reg;
        kj_next    = kj_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_clear)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    cnt_next = cnt_reg + STEP_W'(1);
                end
            end
            S_EVAL:
            begin
                priority if (stat.outside)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.is_seed)
                begin
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_SQ;
                    cnt_next   = '0;
                end
            end
            S_SQ:
            begin
                if (cnt_reg == STEP_W'(SQ_OPS - 1))
                begin
                    state_next = S_SCAN_RD;
                    ki_next    = '0;
                    kj_next    = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + STEP_W'(1);
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                priority if (stat.hit)
                begin
                    state_next = S_IDLE;
                end
                else if (ki_reg == WIN_W'(WIN - 1))
                begin
                    if (kj_reg == WIN_W'(WIN - 1))
                    begin
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        ki_next = '0;
                        kj_next = kj_reg + WIN_W'(1);
                    end
                end
                else
                begin
                    ki_next = ki_reg + WIN_W'(1);
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.sq_idx      = cnt_reg[SQ_IDX_W-1:0];
        cmd.ki          = ki_reg;
        cmd.kj          = kj_reg;
        cmd.emit_status = STAT_ACCEPTED;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_DISPATCH:
            begin
                if (stat.is_clear)
                begin
                    cmd.clr         = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = STAT_CLEARED;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_EVAL:
            begin
                if (stat.outside)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = STAT_OUTSIDE;
                end
            end
            S_SQ:
            begin
                cmd.sq_en = 1'b1;
            end
            S_SCAN_RD:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_kj = '0;
            end
            S_SCAN:
            begin
                cmd.scan_chk = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_kj    = (ki_reg == WIN_W'(WIN - 1)) ? kj_reg + WIN_W'(1) : kj_reg;
                if (stat.hit)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = STAT_TOO_CLOSE;
                end
            end
            S_INS_RD:
            begin
                cmd.ins_rd = 1'b1;
            end
            S_INS_WR:
            begin
                cmd.ins_wr      = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = STAT_ACCEPTED;
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[design/pdag_dp.sv]
// Datapath: registers, cell dividers, edge gap squares, scan test, grid, counter.
module pdag_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pdag_pkg::ctrl_cmd_t             cmd,
    output pdag_pkg::dp_stat_t              stat,
    input  logic [pdag_pkg::FUNC_W-1:0]     func,
    input  logic [pdag_pkg::COORD_W-1:0]    cand_x,
    input  logic [pdag_pkg::COORD_W-1:0]    cand_y,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pdag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdag_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output logic [pdag_pkg::STATUS_W-1:0]   status,
    output logic [pdag_pkg::OUT_COL_W-1:0]  cell_col,
    output logic [pdag_pkg::OUT_ROW_W-1:0]  cell_row,
    output logic [pdag_pkg::CNT_W-1:0]      accepted_count
);
    import pdag_pkg::*;

    function automatic logic [GAP_W-1:0] edge_gap(
        input logic [REM_W-1:0] r,
        input logic [CS_W-1:0]  cs,
        input logic [WIN_W-1:0] k
    );
        logic signed [DIFF_W-1:0] two_r;
        logic signed [DIFF_W-1:0] cs1;
        logic signed [DIFF_W-1:0] cs3;
        logic signed [DIFF_W-1:0] cs5;
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] mag;
        two_r = DIFF_W'({r, 1'b0});
        cs1   = DIFF_W'(cs);
        cs3   = cs1 + (cs1 <<< 1);
        cs5   = cs1 + (cs1 <<< 2);
        // offset from the candidate's own cell: k=0 is two cells left
        unique case (k)
            3'd0:    diff = two_r + cs3;
            3'd1:    diff = two_r + cs1;
            3'd2:    diff = two_r - cs1;
            3'd3:    diff = two_r - cs3;
            default: diff = two_r - cs5;
        endcase
        if (diff < 0)
        begin
            diff = -diff;
        end
        mag = diff - cs1;
        if (mag < 0)
        begin
            mag = '0;
        end
        return mag[GAP_W-1:0];
    endfunction

    logic [DIM_W-1:0]     area_w_reg;
    logic [DIM_W-1:0]     area_h_reg;
    logic [SP_W-1:0]      spacing_reg;
    logic [CS_W-1:0]      cell_size_reg;
    logic [CS_W-1:0]      cs_eff;

    logic [FUNC_W-1:0]    func_reg;
    logic [COORD_W-1:0]   x_reg;
    logic [COORD_W-1:0]   y_reg;

    logic [QUO_W-1:0]     quo_x;
    logic [QUO_W-1:0]     quo_y;
    logic [QUO_W-1:0]     quo_w;
    logic [QUO_W-1:0]     quo_h;
    logic [REM_W-1:0]     rem_x;
    logic [REM_W-1:0]     rem_y;

    logic [SQ_W-1:0]      dx2_reg [WIN];
    logic [SQ_W-1:0]      dy2_reg [WIN];
    logic [SQ_W-1:0]      lim2_reg;
    logic [GAP_W-1:0]     sq_opnd;
    logic [SQ_W-1:0]      sq_prod;
    logic [WIN_W-1:0]     dy_k;

    logic [POS_W-1:0]     i_pos;
    logic [POS_W-1:0]     j_pos;
    logic [POS_W-1:0]     jr_pos;
    logic                 act_i;
    logic                 act_j;
    logic [SUM_W-1:0]     dist2;
    logic                 scan_hit;
    logic [GRID_COLS-1:0] grid_data;
    logic                 grid_vld;
    logic [GRID_COLS-1:0] occ_row;
    grid_req_t            grid_req;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_inc;

    logic                 done_reg;
    status_t              status_reg;
    logic [OUT_COL_W-1:0] col_out_reg;
    logic [OUT_ROW_W-1:0] row_out_reg;
    logic [CNT_W-1:0]     count_out_reg;

    assign cfg_ready = 1'b1;
    assign cs_eff    = (cell_size_reg == '0) ? CS_W'(1) : cell_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_w_reg    <= AREA_WIDTH_RST;
            area_h_reg    <= AREA_HEIGHT_RST;
            spacing_reg   <= SPACING_RST;
            cell_size_reg <= CELL_SIZE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_AREA_WIDTH:  area_w_reg    <= cfg_data[DIM_W-1:0];
                CFG_AREA_HEIGHT: area_h_reg    <= cfg_data[DIM_W-1:0];
                CFG_SPACING:     spacing_reg   <= cfg_data[SP_W-1:0];
                CFG_CELL_SIZE:   cell_size_reg <= cfg_data[CS_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            x_reg    <= cand_x;
            y_reg    <= cand_y;
        end
    end

    pdag_div u_div_x (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.div_step),
        .dividend (cand_x[QUO_W-1:0]),
        .divisor  (cs_eff),
        .quot     (quo_x),
        .rem      (rem_x)
    );

    pdag_div u_div_y (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.div_step),
        .dividend (cand_y[QUO_W-1:0]),
        .divisor  (cs_eff),
        .quot     (quo_y),
        .rem      (rem_y)
    );

    pdag_div u_div_w (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.div_step),
        .dividend (area_w_reg),
        .divisor  (cs_eff),
        .quot     (quo_w),
        .rem      ()
    );

    pdag_div u_div_h (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.div_step),
        .dividend (area_h_reg),
        .divisor  (cs_eff),
        .quot     (quo_h),
        .rem      ()
    );

    // the active grid ends at min(grid size, area / cell_size + 1)
    always_comb
    begin
        stat.is_clear = func_reg[FUNC_CLEAR_BIT];
        stat.is_seed  = (func_reg == FUNC_SEED);
        stat.outside  = x_reg[COORD_W-1] || y_reg[COORD_W-1]
                     || (x_reg[DIM_W-1:0] >= area_w_reg)
                     || (y_reg[DIM_W-1:0] >= area_h_reg)
                     || (quo_x >= QUO_W'(GRID_COLS)) || (quo_x > quo_w)
                     || (quo_y >= QUO_W'(GRID_ROWS)) || (quo_y > quo_h);
        stat.hit      = scan_hit;
    end

    assign dy_k = WIN_W'(cmd.sq_idx - SQ_IDX_W'(WIN));

    always_comb
    begin
        if (cmd.sq_idx < SQ_IDX_W'(WIN))
        begin
            sq_opnd = edge_gap(rem_x, cs_eff, cmd.sq_idx[WIN_W-1:0]);
        end
        else if (cmd.sq_idx < SQ_IDX_W'(2 * WIN))
        begin
            sq_opnd = edge_gap(rem_y, cs_eff, dy_k);
        end
        else
        begin
            sq_opnd = GAP_W'({spacing_reg, 1'b0});
        end
    end

    assign sq_prod = SQ_W'(sq_opnd) * SQ_W'(sq_opnd);

    always_ff @(posedge clk)
    begin
        if (cmd.sq_en)
        begin
            if (cmd.sq_idx < SQ_IDX_W'(WIN))
            begin
                dx2_reg[cmd.sq_idx[WIN_W-1:0]] <= sq_prod;
            end
            else if (cmd.sq_idx < SQ_IDX_W'(2 * WIN))
            begin
                dy2_reg[dy_k] <= sq_prod;
            end
            else
            begin
                lim2_reg <= sq_prod;
            end
        end
    end

    // window positions; a negative value shows as a set top bit
    always_comb
    begin
        i_pos   = POS_W'(quo_x) + POS_W'(cmd.ki) - POS_W'(HALF_WIN);
        j_pos   = POS_W'(quo_y) + POS_W'(cmd.kj) - POS_W'(HALF_WIN);
        jr_pos  = POS_W'(quo_y) + POS_W'(cmd.rd_kj) - POS_W'(HALF_WIN);
        act_i   = !i_pos[POS_W-1] && (i_pos <= POS_W'(quo_w)) && (i_pos < POS_W'(GRID_COLS));
        act_j   = !j_pos[POS_W-1] && (j_pos <= POS_W'(quo_h)) && (j_pos < POS_W'(GRID_ROWS));
        occ_row = grid_vld ? grid_data : '0;
        dist2   = SUM_W'(dx2_reg[cmd.ki]) + SUM_W'(dy2_reg[cmd.kj]);
        scan_hit = cmd.scan_chk && act_i && act_j && occ_row[i_pos[COL_W-1:0]]
                && (dist2 < SUM_W'(lim2_reg));
    end

    always_comb
    begin
        grid_req.rd_en   = cmd.rd_en || cmd.ins_rd;
        grid_req.rd_addr = cmd.ins_rd ? quo_y[ROW_W-1:0] : jr_pos[ROW_W-1:0];
        grid_req.wr_en   = cmd.ins_wr;
        grid_req.wr_addr = quo_y[ROW_W-1:0];
        grid_req.wr_data = occ_row | (GRID_COLS'(1) << quo_x[COL_W-1:0]);
        grid_req.clr     = cmd.clr;
    end

    pdag_grid u_grid (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (grid_req),
        .rd_data (grid_data),
        .rd_vld  (grid_vld)
    );

    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.ins_wr)
            begin
                count_reg <= count_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg <= cmd.emit_status;
            unique case (cmd.emit_status)
                STAT_ACCEPTED:
                begin
                    col_out_reg   <= quo_x[OUT_COL_W-1:0];
                    row_out_reg   <= quo_y[OUT_ROW_W-1:0];
                    count_out_reg <= count_inc;
                end
                STAT_TOO_CLOSE:
                begin
                    col_out_reg   <= quo_x[OUT_COL_W-1:0];
                    row_out_reg   <= quo_y[OUT_ROW_W-1:0];
                    count_out_reg <= count_reg;
                end
                STAT_OUTSIDE:
                begin
                    col_out_reg   <= '0;
                    row_out_reg   <= '0;
                    count_out_reg <= count_reg;
                end
                STAT_CLEARED:
                begin
                    col_out_reg   <= '0;
                    row_out_reg   <= '0;
                    count_out_reg <= '0;
                end
            endcase
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign cell_col       = col_out_reg;
    assign cell_row       = row_out_reg;
    assign accepted_count = count_out_reg;

endmodule

[design/poisson_disk_admission_grid_core.sv]
// Top level of the Poisson disk admission grid: controller plus datapath.
// A test runs through the 13-step cell divider, 11 squarings on one multiplier and
// the 25-cell scan through one registered row-read port of the grid memory, with an
// early exit on the first close cell; a seed skips the squarings and the scan, an
// outside point stops after the divider, and a clear skips all of them.
// start is taken again in the cycle done is high; results are never stalled.
// Reset (rst_n low, async) empties the grid via row valid flags, zeroes the counter.
module poisson_disk_admission_grid_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pdag_pkg::FUNC_W-1:0]     func,
    input  logic [pdag_pkg::COORD_W-1:0]    cand_x,
    input  logic [pdag_pkg::COORD_W-1:0]    cand_y,
    output logic                            done,
    output logic [pdag_pkg::STATUS_W-1:0]   status,
    output logic [pdag_pkg::OUT_COL_W-1:0]  cell_col,
    output logic [pdag_pkg::OUT_ROW_W-1:0]  cell_row,
    output logic [pdag_pkg::CNT_W-1:0]      accepted_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pdag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdag_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pdag_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    pdag_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    pdag_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .func           (func),
        .cand_x         (cand_x),
        .cand_y         (cand_y),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .status         (status),
        .cell_col       (cell_col),
        .cell_row       (cell_row),
        .accepted_count (accepted_count)
    );

endmodule

[design/pdag_checker.sv]
// Port-level checker for the admission grid core, bound to the top level.
`include "poisson_disk_admission_grid_core_defines.svh"

module pdag_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [pdag_pkg::STATUS_W-1:0]  status,
    input logic [pdag_pkg::OUT_COL_W-1:0] cell_col,
    input logic [pdag_pkg::OUT_ROW_W-1:0] cell_row,
    input logic [pdag_pkg::CNT_W-1:0]     accepted_count
);
    import pdag_pkg::*;

    `PDAG_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `PDAG_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")
    `PDAG_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `PDAG_ASSERT_SAME(a_busy_fall, $fell(busy), done, "busy dropped without a result")
    `PDAG_ASSERT_SAME(a_clear_zero, done && (status == STAT_CLEARED), (accepted_count == '0) && (cell_col == '0) && (cell_row == '0), "clear result not zero")

endmodule

bind poisson_disk_admission_grid_core pdag_checker u_pdag_checker (.*);

[dv/tb_top.sv]
// Testbench for the Poisson disk admission grid core: queued stimulus, in-line predictor, checks.
module tb_top;
    import pdag_pkg::*;

    localparam logic [FUNC_W-1:0] FN_TEST      = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SEED      = FUNC_SEED;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR_ALT = 2'd3;
    localparam int QUIET_CYCLES = 4;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 60;

    typedef struct {
        bit                    is_cfg;
        logic [FUNC_W-1:0]     fn;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        int                    gap;
    } op_t;

    typedef struct {
        status_t              st;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic [CNT_W-1:0]     cnt;
    } admission_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic [FUNC_W-1:0]     func           = '0;
    logic [COORD_W-1:0]    cand_x         = '0;
    logic [COORD_W-1:0]    cand_y         = '0;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [OUT_COL_W-1:0]  cell_col;
    logic [OUT_ROW_W-1:0]  cell_row;
    logic [CNT_W-1:0]      accepted_count;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    poisson_disk_admission_grid_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .cand_x         (cand_x),
        .cand_y         (cand_y),
        .done           (done),
        .status         (status),
        .cell_col       (cell_col),
        .cell_row       (cell_row),
        .accepted_count (accepted_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [DIM_W-1:0]     m_area_w    = AREA_WIDTH_RST;
    logic [DIM_W-1:0]     m_area_h    = AREA_HEIGHT_RST;
    logic [SP_W-1:0]      m_spacing   = SPACING_RST;
    logic [CS_W-1:0]      m_cell_size = CELL_SIZE_RST;
    bit [GRID_COLS-1:0]   m_occ [GRID_ROWS];
    int unsigned          m_count     = 0;

    op_t        pending_ops[$];
    admission_t expected_results[$];
    int         mismatch_count = 0;
    int         plan_aw = AREA_WIDTH_RST;
    int         plan_ah = AREA_HEIGHT_RST;

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic longint edge_gap(input longint pos, input longint idx, input longint cs);
        longint d;
        d = 2 * pos - (2 * idx * cs + cs);
        if (d < 0)
            d = -d;
        d = d - cs;
        return (d < 0) ? 0 : d;
    endfunction

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_AREA_WIDTH:  m_area_w    = data[DIM_W-1:0];
            CFG_AREA_HEIGHT: m_area_h    = data[DIM_W-1:0];
            CFG_SPACING:     m_spacing   = data[SP_W-1:0];
            CFG_CELL_SIZE:   m_cell_size = data[CS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_admission(input logic [FUNC_W-1:0] fn,
                                     input logic [COORD_W-1:0] xr,
                                     input logic [COORD_W-1:0] yr);
        longint     x, y, cs, col, row, lim_c, lim_r, lim2, dx, dy, i, j;
        bit         too_close;
        admission_t res;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        cs = (m_cell_size == 0) ? 1 : longint'(m_cell_size);
        too_close = 1'b0;
        res.st = STAT_ACCEPTED;
        res.col = '0;
        res.row = '0;
        res.cnt = '0;
        if (fn[FUNC_CLEAR_BIT]) begin
            foreach (m_occ[k])
                m_occ[k] = '0;
            m_count = 0;
            res.st = STAT_CLEARED;
        end
        else begin
            lim_c = longint'(m_area_w) / cs + 1;
            if (lim_c > GRID_COLS)
                lim_c = GRID_COLS;
            lim_r = longint'(m_area_h) / cs + 1;
            if (lim_r > GRID_ROWS)
                lim_r = GRID_ROWS;
            col = x / cs;
            row = y / cs;
            if (x < 0 || y < 0 || x >= longint'(m_area_w) || y >= longint'(m_area_h) ||
                col >= lim_c || row >= lim_r) begin
                res.st = STAT_OUTSIDE;
                res.cnt = CNT_W'(m_count);
            end
            else begin
                if (fn == FN_TEST) begin
                    lim2 = 4 * longint'(m_spacing) * longint'(m_spacing);
                    for (i = col - 2; i <= col + 2; i++)
                        for (j = row - 2; j <= row + 2; j++)
                            if (i >= 0 && i < lim_c && j >= 0 && j < lim_r && m_occ[j][i]) begin
                                dx = edge_gap(x, i, cs);
                                dy = edge_gap(y, j, cs);
                                if (dx * dx + dy * dy < lim2)
                                    too_close = 1'b1;
                            end
                end
                if (too_close)
                    res.st = STAT_TOO_CLOSE;
                else begin
                    m_occ[row][col] = 1'b1;
                    if (m_count < COUNT_MAX)
                        m_count++;
                    res.st = STAT_ACCEPTED;
                end
                res.col = OUT_COL_W'(col);
                res.row = OUT_ROW_W'(row);
                res.cnt = CNT_W'(m_count);
            end
        end
        expected_results.insert(expected_results.size(), res);
    endtask

    // driver
    op_t cur_op;
    bit  op_loaded = 1'b0;
    bit  present;
    int  hold_cnt  = 0;
    int  in_flight = 0;
    int  quiet_cnt = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start     <= 1'b0;
            func      <= '0;
            cand_x    <= '0;
            cand_y    <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else begin
            if (start && !busy) begin
                predict_admission(func, cand_x, cand_y);
                in_flight++;
                op_loaded = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                apply_register(cfg_index, cfg_data);
                op_loaded = 1'b0;
            end
            if (done)
                in_flight--;
            quiet_cnt = (in_flight == 0) ? quiet_cnt + 1 : 0;
            if (!op_loaded) begin
                if (pending_ops.size() != 0 &&
                    (!pending_ops[0].is_cfg || quiet_cnt >= QUIET_CYCLES)) begin
                    cur_op = pending_ops.pop_front();
                    op_loaded = 1'b1;
                    hold_cnt = cur_op.gap;
                end
            end
            else if (hold_cnt > 0) begin
                hold_cnt--;
            end
            present = op_loaded && hold_cnt == 0;
            start     <= present && !cur_op.is_cfg;
            cfg_valid <= present && cur_op.is_cfg;
            if (present) begin
                func      <= cur_op.fn;
                cand_x    <= cur_op.x;
                cand_y    <= cur_op.y;
                cfg_index <= cur_op.idx;
                cfg_data  <= cur_op.data;
            end
        end
    end

    // monitor
    admission_t want_res;

    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result, status %0d", status));
            end
            else begin
                want_res = expected_results.pop_front();
                if (status !== want_res.st)
                    flag_mismatch($sformatf("status %0d, want %0d", status, want_res.st));
                if (cell_col !== want_res.col)
                    flag_mismatch($sformatf("cell_col %0d, want %0d", cell_col, want_res.col));
                if (cell_row !== want_res.row)
                    flag_mismatch($sformatf("cell_row %0d, want %0d", cell_row, want_res.row));
                if (accepted_count !== want_res.cnt)
                    flag_mismatch($sformatf("accepted_count %0d, want %0d",
                                            accepted_count, want_res.cnt));
            end
        end
    end

    // stimulus building
    function automatic int any_coord();
        return int'($urandom_range(0, 16383)) - 8192;
    endfunction

    function automatic int pick_coord(input int extent);
        if (extent <= 0)
            return any_coord();
        return int'($urandom_range(0, extent - 1));
    endfunction

    function automatic int draw_gap(input int mode);
        case (mode)
            0:       return 0;
            1:       return int'($urandom_range(0, 6));
            default: return ($urandom_range(0, 9) == 0) ? 6 : 0;
        endcase
    endfunction

    task automatic add_item(input logic [FUNC_W-1:0] fn, input int x, input int y,
                            input int gap);
        op_t op;
        op.is_cfg = 1'b0;
        op.fn     = fn;
        op.x      = x[COORD_W-1:0];
        op.y      = y[COORD_W-1:0];
        op.idx    = '0;
        op.data   = '0;
        op.gap    = gap;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        op_t op;
        op.is_cfg = 1'b1;
        op.fn     = '0;
        op.x      = '0;
        op.y      = '0;
        op.idx    = idx;
        op.data   = data;
        op.gap    = int'($urandom_range(0, 6));
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic set_config(input int aw, input int ah, input int sp, input int cs);
        logic [CFG_DATA_W-1:0] sp_word, cs_word;
        sp_word = {2'($urandom_range(0, 3)), sp[SP_W-1:0]};
        cs_word = {2'($urandom_range(0, 3)), cs[CS_W-1:0]};
        if ($urandom_range(0, 1)) begin
            add_cfg(CFG_CELL_SIZE, cs_word);
            add_cfg(CFG_SPACING, sp_word);
        end
        else begin
            add_cfg(CFG_SPACING, sp_word);
            add_cfg(CFG_CELL_SIZE, cs_word);
        end
        add_cfg(CFG_AREA_WIDTH, aw[CFG_DATA_W-1:0]);
        add_cfg(CFG_AREA_HEIGHT, ah[CFG_DATA_W-1:0]);
        plan_aw = aw & 32'h1FFF;
        plan_ah = ah & 32'h1FFF;
    endtask

    task automatic add_random_items(input int n, input int mode);
        int r, g;
        for (int k = 0; k < n; k++) begin
            r = int'($urandom_range(0, 99));
            g = draw_gap(mode);
            if (r < 3)
                add_item(r[0] ? FN_CLEAR_ALT : FN_CLEAR, any_coord(), any_coord(), g);
            else if (r < 13)
                add_item(r[0] ? FN_SEED : FN_TEST, any_coord(), any_coord(), g);
            else if (r < 18)
                add_item(FN_TEST, plan_aw - int'($urandom_range(0, 1)), pick_coord(plan_ah), g);
            else if (r < 30)
                add_item(FN_SEED, pick_coord(plan_aw), pick_coord(plan_ah), g);
            else
                add_item(FN_TEST, pick_coord(plan_aw), pick_coord(plan_ah), g);
        end
    endtask

    initial
    begin
        int sp, cs;

        // directed, reset configuration
        add_item(FN_TEST, 0, 0, draw_gap(1));
        add_item(FN_TEST, 0, 0, draw_gap(1));
        add_item(FN_TEST, 1023, 767, draw_gap(1));
        add_item(FN_TEST, 1024, 0, draw_gap(1));
        add_item(FN_TEST, 0, 768, draw_gap(1));
        add_item(FN_TEST, -1, 5, draw_gap(1));
        add_item(FN_TEST, -8192, -8192, draw_gap(1));
        add_item(FN_TEST, 8191, 8191, draw_gap(1));
        add_item(FN_SEED, 0, 0, draw_gap(1));
        add_item(FN_SEED, -5, 10, draw_gap(1));
        add_item(FN_TEST, 130, 0, draw_gap(1));
        add_item(FN_TEST, 100, 40, draw_gap(1));
        add_item(FN_CLEAR_ALT, 8191, -8192, draw_gap(1));
        add_item(FN_TEST, 0, 0, draw_gap(1));
        add_item(FN_CLEAR, -1, -1, draw_gap(1));
        // zero cell size and zero spacing, grid capped at its maximum extent
        set_config(8191, 8191, 0, 0);
        add_item(FN_TEST, 10, 10, 0);
        add_item(FN_TEST, 10, 10, 0);
        add_item(FN_TEST, 64, 3, 0);
        add_item(FN_TEST, 63, 63, 0);
        // zero width area
        set_config(0, 768, 64, 45);
        add_item(FN_TEST, 0, 0, 0);
        add_item(FN_SEED, 0, 0, 0);
        // single point area with the widest cell and spacing
        set_config(1, 1, 2047, 2047);
        add_item(FN_TEST, 0, 0, 0);
        add_item(FN_TEST, 0, 0, 0);

        // repeated seeds into a small grid, where several can land in the same cell
        set_config(64, 64, 8, 6);
        add_item(FN_CLEAR, 0, 0, 0);
        repeat (20)
            add_item(FN_SEED, pick_coord(64), pick_coord(64), 0);
        repeat (5)
            add_item(FN_TEST, pick_coord(64), pick_coord(64), draw_gap(1));
        add_item(FN_CLEAR, 0, 0, 0);

        set_config(1024, 768, 64, 45);
        add_random_items(40, 1);
        set_config(200, 150, 20, 14);
        add_random_items(40, 0);
        set_config(4096, 4096, 1024, 724);
        add_random_items(40, 2);
        set_config(4096, 3000, 40, 32);
        add_random_items(50, 1);
        set_config(8191, 8191, 2047, 2047);
        add_random_items(40, 1);
        set_config(1, 1, 1, 1);
        add_random_items(30, 2);
        sp = int'($urandom_range(1, 1024));
        cs = (sp * 707) / 1000;
        set_config(int'($urandom_range(1, 4096)), int'($urandom_range(1, 4096)), sp,
                   (cs < 1) ? 1 : cs);
        add_random_items(50, 1);
        set_config(100, 100, 0, 0);
        add_random_items(40, 0);
        set_config(int'($urandom_range(0, 8191)), int'($urandom_range(0, 8191)),
                   int'($urandom_range(0, 2047)), int'($urandom_range(0, 2047)));
        add_random_items(40, 1);
        set_config(300, 300, 30, 21);
        add_random_items(40, 2);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || op_loaded || in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
